// ===== rtl/core/irptt_pkg.sv =====
`timescale 1ns / 1ps

package irptt_pkg;

	// command codes carried in the low bits of the input word
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_START = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	// register indexes, byte address is four times the index
	typedef enum logic [2:0] {
		REG_CODE_LENGTH    = 3'd0,
		REG_REPEAT_COUNT   = 3'd1,
		REG_GAP_US         = 3'd2,
		REG_CARRIER_PERIOD = 3'd3,
		REG_TICK_DIVIDER   = 3'd4
	} reg_idx_t;

	// field widths
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned LEN_W   = 9;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned DIV_W   = 9;
	localparam int unsigned PSC_W   = 8;

	// register reset values
	localparam logic [LEN_W-1:0] CODE_LENGTH_RST    = 9'd1;
	localparam logic [CNT_W-1:0] REPEAT_COUNT_RST   = 16'd1;
	localparam logic [CNT_W-1:0] GAP_US_RST         = 16'd10000;
	localparam logic [CNT_W-1:0] CARRIER_PERIOD_RST = 16'd1894;
	localparam logic [DIV_W-1:0] TICK_DIVIDER_RST   = 9'd72;

	// limits applied to register values
	localparam logic [DIV_W-1:0] DIV_MAX    = 9'd256;
	localparam logic [CNT_W-1:0] PERIOD_MIN = 16'd2;

endpackage

// ===== rtl/core/ir_pulse_train_transmitter.sv =====
`timescale 1ns / 1ps

// Infrared pulse-train transmitter. Each input word is one command: a clock
// tick, a write into the duration store, start or stop. Every word yields one
// result word with the pin level, the mark envelope, busy and done. One word
// is taken every cycle while no result is held back; a word passes an input
// register and then a result register, and while a result waits the next
// word stays in the input register. The store is a RAM with a
// registered read port that always fetches the entry after the current one,
// and entry 0 is kept in a shadow register, so each step needs no wait. The
// store holds no reset value: every entry within the code length must be
// written before a start. Registers may be written only while no word is in
// flight; a change made while sending takes effect on the next word.

module ir_pulse_train_transmitter
	import irptt_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES   = 256,
	parameter int unsigned DURATION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // cmd[1:0], entry_index[9:2], entry_value[25:10]
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // ir_out[0], envelope[1], busy_res[2], done_res[3]
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned AW   = $clog2(MAX_ENTRIES);
	localparam int unsigned LW   = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
	localparam int unsigned DL_W = (DURATION_BITS > CNT_W) ? DURATION_BITS : CNT_W;

	// configuration registers
	logic [LEN_W-1:0] code_length_q;
	logic [CNT_W-1:0] repeat_count_q;
	logic [CNT_W-1:0] gap_us_q;
	logic [CNT_W-1:0] carrier_period_q;
	logic [DIV_W-1:0] tick_divider_q;
	logic             cfg_we;
	reg_idx_t         cfg_idx;

	// input stage
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic [VALUE_W-1:0] val_s1;
	logic               adv;

	// result register
	logic       out_valid_q;
	logic [3:0] out_data_q;
	logic [3:0] out_data_d;

	// transmitter state
	logic [AW-1:0]    pos_q, pos_d;
	logic [CNT_W-1:0] rl_q, rl_d;
	logic [DL_W-1:0]  dl_q, dl_d;
	logic [PSC_W-1:0] ps_q, ps_d;
	logic [CNT_W-1:0] cc_q, cc_d;
	logic             gap_q, gap_d;
	logic             send_q, send_d;

	// duration store
	logic [DURATION_BITS-1:0] mem [MAX_ENTRIES];
	logic [DURATION_BITS-1:0] mem_rd_q;
	logic [DURATION_BITS-1:0] head_q;
	logic [DURATION_BITS-1:0] mem_wdata;
	logic [AW-1:0]            mem_waddr;
	logic [AW-1:0]            mem_raddr;
	logic                     mem_we;

	// effective settings
	logic [LW-1:0]    len_eff;
	logic [DIV_W-1:0] div_eff;
	logic [CNT_W-1:0] period_eff;

	// datapath values
	logic [CNT_W-1:0] cc_adj;
	logic [CNT_W:0]   cc_inc;
	logic             carrier;
	logic             env;
	logic             busy;
	logic             done;
	logic [DIV_W-1:0] ps_inc;
	logic [DL_W-1:0]  dl_dec;
	logic [LW-1:0]    pos_inc;
	logic [CNT_W-1:0] rl_dec;
	logic [DL_W-1:0]  head_dur;
	logic [DL_W-1:0]  next_dur;
	logic [DL_W-1:0]  gap_dur;
	logic [CNT_W-1:0] rep_load;
	logic             idx_ok;

	// register port
	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q    <= CODE_LENGTH_RST;
			repeat_count_q   <= REPEAT_COUNT_RST;
			gap_us_q         <= GAP_US_RST;
			carrier_period_q <= CARRIER_PERIOD_RST;
			tick_divider_q   <= TICK_DIVIDER_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CODE_LENGTH:    code_length_q    <= pwdata[LEN_W-1:0];
				REG_REPEAT_COUNT:   repeat_count_q   <= pwdata[CNT_W-1:0];
				REG_GAP_US:         gap_us_q         <= pwdata[CNT_W-1:0];
				REG_CARRIER_PERIOD: carrier_period_q <= pwdata[CNT_W-1:0];
				REG_TICK_DIVIDER:   tick_divider_q   <= pwdata[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_CODE_LENGTH:    prdata = 32'(code_length_q);
			REG_REPEAT_COUNT:   prdata = 32'(repeat_count_q);
			REG_GAP_US:         prdata = 32'(gap_us_q);
			REG_CARRIER_PERIOD: prdata = 32'(carrier_period_q);
			REG_TICK_DIVIDER:   prdata = 32'(tick_divider_q);
			default:            prdata = '0;
		endcase
	end

	// handshake: the input stage moves whenever the result register frees up
	assign adv           = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1 <= cmd_t'(s_axis_tdata[1:0]);
			idx_s1 <= s_axis_tdata[9:2];
			val_s1 <= s_axis_tdata[25:10];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= out_data_d;
		end
	end

	// effective settings with out-of-range values clamped
	always_comb begin
		if (code_length_q == '0) begin
			len_eff = LW'(1);
		end else if (LW'(code_length_q) > LW'(MAX_ENTRIES)) begin
			len_eff = LW'(MAX_ENTRIES);
		end else begin
			len_eff = LW'(code_length_q);
		end
		if (tick_divider_q == '0) begin
			div_eff = DIV_W'(1);
		end else if (tick_divider_q > DIV_MAX) begin
			div_eff = DIV_MAX;
		end else begin
			div_eff = tick_divider_q;
		end
		period_eff = (carrier_period_q < PERIOD_MIN) ? PERIOD_MIN : carrier_period_q;
	end

	// durations for the next segment, zero lasts one tick
	assign head_dur = (head_q == '0) ? DL_W'(1) : DL_W'(head_q);
	assign next_dur = (mem_rd_q == '0) ? DL_W'(1) : DL_W'(mem_rd_q);
	assign gap_dur  = (gap_us_q == '0) ? DL_W'(1) : DL_W'(gap_us_q);
	assign rep_load = (repeat_count_q == '0) ? CNT_W'(1) : repeat_count_q;

	// carrier, counters and sequencing
	assign cc_adj  = (cc_q >= period_eff) ? '0 : cc_q;
	assign carrier = cc_adj < (period_eff >> 1);
	assign cc_inc  = {1'b0, cc_adj} + (CNT_W + 1)'(1);
	assign ps_inc  = {1'b0, ps_q} + DIV_W'(1);
	assign dl_dec  = (dl_q != '0) ? dl_q - DL_W'(1) : '0;
	assign pos_inc = LW'(pos_q) + LW'(1);
	assign rl_dec  = rl_q - CNT_W'(1);
	assign idx_ok  = LW'(idx_s1) < LW'(MAX_ENTRIES);

	always_comb begin
		pos_d  = pos_q;
		rl_d   = rl_q;
		dl_d   = dl_q;
		ps_d   = ps_q;
		cc_d   = cc_q;
		gap_d  = gap_q;
		send_d = send_q;
		done   = 1'b0;
		env    = send_q & ~gap_q & ~pos_q[0];
		busy   = send_q;
		mem_we = 1'b0;
		if (valid_s1) begin
			cc_d = cc_adj;
			unique case (cmd_s1)
				CMD_TICK: begin
					cc_d = (cc_inc == {1'b0, period_eff}) ? '0 : cc_inc[CNT_W-1:0];
					if (send_q) begin
						if (ps_inc >= div_eff) begin
							ps_d = '0;
							dl_d = dl_dec;
							if (dl_dec == '0) begin
								if (gap_q) begin
									gap_d = 1'b0;
									pos_d = '0;
									dl_d  = head_dur;
								end else if (pos_inc < len_eff) begin
									pos_d = pos_inc[AW-1:0];
									dl_d  = next_dur;
								end else begin
									rl_d = rl_dec;
									if (rl_dec == '0) begin
										send_d = 1'b0;
										gap_d  = 1'b0;
										pos_d  = '0;
										dl_d   = '0;
										ps_d   = '0;
										done   = 1'b1;
									end else begin
										gap_d = 1'b1;
										dl_d  = gap_dur;
									end
								end
							end
						end else begin
							ps_d = ps_inc[PSC_W-1:0];
						end
					end
				end
				CMD_WRITE: begin
					mem_we = ~send_q & idx_ok;
				end
				CMD_START: begin
					send_d = 1'b1;
					gap_d  = 1'b0;
					ps_d   = '0;
					rl_d   = rep_load;
					pos_d  = '0;
					dl_d   = head_dur;
				end
				CMD_STOP: begin
					send_d = 1'b0;
					gap_d  = 1'b0;
					pos_d  = '0;
					dl_d   = '0;
					ps_d   = '0;
					rl_d   = '0;
				end
				default: ;
			endcase
			// commands other than a tick report the state they leave behind
			if (cmd_s1 != CMD_TICK) begin
				env  = send_d & ~gap_d & ~pos_d[0];
				busy = send_d;
			end
		end
		out_data_d = {done, busy, env, carrier & env};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			rl_q   <= '0;
			dl_q   <= '0;
			ps_q   <= '0;
			cc_q   <= '0;
			gap_q  <= 1'b0;
			send_q <= 1'b0;
		end else if (adv) begin
			pos_q  <= pos_d;
			rl_q   <= rl_d;
			dl_q   <= dl_d;
			ps_q   <= ps_d;
			cc_q   <= cc_d;
			gap_q  <= gap_d;
			send_q <= send_d;
		end
	end

	// duration store, read port always fetches the entry after the current one
	assign mem_wdata = DURATION_BITS'(val_s1);
	assign mem_waddr = AW'(idx_s1);
	assign mem_raddr = (adv ? pos_d : pos_q) == AW'(MAX_ENTRIES - 1) ? '0
		: (adv ? pos_d : pos_q) + AW'(1);

	always_ff @(posedge clk) begin
		if (adv && mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (adv && mem_we && mem_waddr == mem_raddr) begin
			mem_rd_q <= mem_wdata;
		end else begin
			mem_rd_q <= mem[mem_raddr];
		end
	end

	// shadow copy of entry 0 for start and for the wrap after a gap
	always_ff @(posedge clk) begin
		if (adv && mem_we && mem_waddr == '0) begin
			head_q <= mem_wdata;
		end
	end

endmodule
